/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rolling hash matcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rhsm_pkg.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher package
// Hash constants, operation codes and the modular unit request/response types.
// ----------------------------------------------------------------------------
package rhsm_pkg;

    localparam int HASH_W = 30;

    localparam logic [HASH_W-1:0] HASH_BASE     = 30'd100050001;
    localparam logic [HASH_W-1:0] HASH_BASE_INV = 30'd678791932;
    localparam logic [HASH_W-1:0] HASH_MOD      = 30'd1000000007;

    // Barrett reciprocal floor(2^60 / HASH_MOD), fits in 31 bits
    localparam logic [63:0] BARRETT_MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    // Request to the shared unit: value = (a * b + c) mod HASH_MOD
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] c;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] value;
    } mm_rsp_t;

endpackage

/* src/rhsm_mulmod.sv */
// ----------------------------------------------------------------------------
// Modular multiply-add unit
// Computes (a * b + c) mod M on one shared multiplier, using Barrett
// reduction with two final corrections.
// ----------------------------------------------------------------------------
module rhsm_mulmod (
    input  logic             aclk,
    input  logic             aresetn,
    input  rhsm_pkg::mm_req_t req,
    output rhsm_pkg::mm_rsp_t rsp
);

    typedef enum logic [4:0] {
        MM_IDLE = 5'b00001,
        MM_PROD = 5'b00010,
        MM_QEST = 5'b00100,
        MM_QMUL = 5'b01000,
        MM_CORR = 5'b10000
    } mm_state_t;

    localparam logic [31:0] MOD32  = {2'b00, rhsm_pkg::HASH_MOD};
    localparam logic [31:0] MOD2X  = {1'b0, rhsm_pkg::HASH_MOD, 1'b0};

    mm_state_t   state_reg;
    mm_state_t   state_next;

    logic [29:0] a_reg;
    logic [29:0] b_reg;
    logic [29:0] c_reg;
    logic [59:0] x_reg;
    logic [61:0] t_reg;

    logic [30:0] mul_a;
    logic [30:0] mul_b;
    logic [61:0] prod;
    logic [31:0] r_raw;
    logic [31:0] r_fix;

    always_comb begin
        case (state_reg)
            MM_PROD: begin
                mul_a = {1'b0, a_reg};
                mul_b = {1'b0, b_reg};
            end
            MM_QEST: begin
                mul_a = x_reg[59:29];
                mul_b = rhsm_pkg::BARRETT_MU;
            end
            MM_QMUL: begin
                mul_a = t_reg[61:31];
                mul_b = {1'b0, rhsm_pkg::HASH_MOD};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 62'(mul_a) * 62'(mul_b);

    // Remainder is below 3M, so the low 32 bits carry it exactly
    always_comb begin
        r_raw = x_reg[31:0] - t_reg[31:0];
        if (r_raw >= MOD2X) begin
            r_fix = r_raw - MOD2X;
        end else if (r_raw >= MOD32) begin
            r_fix = r_raw - MOD32;
        end else begin
            r_fix = r_raw;
        end
    end

    always_comb begin
        case (state_reg)
            MM_IDLE: state_next = req.start ? MM_PROD : MM_IDLE;
            MM_PROD: state_next = MM_QEST;
            MM_QEST: state_next = MM_QMUL;
            MM_QMUL: state_next = MM_CORR;
            MM_CORR: state_next = MM_IDLE;
            default: state_next = MM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            MM_IDLE: begin
                a_reg <= req.a;
                b_reg <= req.b;
                c_reg <= req.c;
            end
            MM_PROD: x_reg <= prod[59:0] + 60'(c_reg);
            MM_QEST: t_reg <= prod;
            MM_QMUL: t_reg <= prod;
            default: ;
        endcase
    end

    assign rsp.done  = (state_reg == MM_CORR);
    assign rsp.value = r_fix[29:0];

endmodule

/* src/rhsm_ring.sv */
// ----------------------------------------------------------------------------
// Window byte ring
// Single-port-write, registered-read store of recent text bytes.
// ----------------------------------------------------------------------------
module rhsm_ring #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Read returns the stored byte before a same-cycle write lands
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/rolling_hash_substring_matcher.sv */
// Sequence: a start word is handled in ST_IDLE; a pattern word runs ST_PAT_POW (skipped for
//   the first byte), then ST_PAT_HASH; a text word with an empty pattern is only counted.
// Other text words take two shared multiply-add passes plus accept and compare,
//   with s_tready low until done; a match waiting on m_tready stalls the input.
// Reset: aresetn synchronous, active low; clears pattern and text state.
// The window ring holds no reset; only bytes of the current text are read back.
// ----------------------------------------------------------------------------
// Rolling hash substring matcher
// Rabin-Karp matcher: builds a pattern hash, rolls a window hash over the
// text and emits the start index of every window whose hash matches.
// ----------------------------------------------------------------------------
module rolling_hash_substring_matcher #(
    parameter int MAX_PATTERN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] operation, [9:2] char_code, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] match_position
);

    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [PLW-1:0] PLEN_MAX = PLW'(MAX_PATTERN);
    localparam logic [AW-1:0]  POS_LAST = AW'(MAX_PATTERN - 1);
    localparam logic [PLW:0]   RING_SZ  = (PLW+1)'(MAX_PATTERN);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b00000001,
        ST_PAT_POW   = 8'b00000010,
        ST_PAT_HASH  = 8'b00000100,
        ST_FILL_HASH = 8'b00001000,
        ST_FILL_POW  = 8'b00010000,
        ST_ROLL_INV  = 8'b00100000,
        ST_ROLL_ADD  = 8'b01000000,
        ST_CHECK     = 8'b10000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;

    logic [29:0]      phash_reg;
    logic [PLW-1:0]   plen_reg;
    logic [29:0]      top_reg;
    logic [29:0]      wh_reg;
    logic [29:0]      tp_reg;
    logic [31:0]      count_reg;
    logic [PLW-1:0]   fill_reg;
    logic [AW-1:0]    pos_reg;
    logic [7:0]       byte_reg;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;

    logic             s_accept;
    logic [1:0]       in_op;
    logic [7:0]       in_byte;
    logic             text_live;
    logic             match;
    logic             out_free;

    logic [PLW:0]     old_sum;
    logic [AW-1:0]    old_idx;
    logic [7:0]       old_byte;
    logic [30:0]      hsum;
    logic [29:0]      hsub;

    rhsm_pkg::mm_req_t mm_req;
    rhsm_pkg::mm_rsp_t mm_rsp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_op     = s_tdata[1:0];
    assign in_byte   = s_tdata[9:2];
    assign text_live = s_accept && (in_op == rhsm_pkg::OP_TEXT) && (plen_reg != '0);

    assign match    = (wh_reg == phash_reg) && (fill_reg == plen_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Slot of the byte leaving the window: pos - plen, wrapped into the ring
    always_comb begin
        old_sum = (PLW+1)'(pos_reg) + RING_SZ - (PLW+1)'(plen_reg);
        if (old_sum >= RING_SZ) begin
            old_idx = AW'(old_sum - RING_SZ);
        end else begin
            old_idx = AW'(old_sum);
        end
    end

    // Drop the oldest byte: (wh + M - old) mod M
    always_comb begin
        hsum = {1'b0, wh_reg} + {1'b0, rhsm_pkg::HASH_MOD - {22'd0, old_byte}};
        if (hsum >= {1'b0, rhsm_pkg::HASH_MOD}) begin
            hsub = 30'(hsum - {1'b0, rhsm_pkg::HASH_MOD});
        end else begin
            hsub = hsum[29:0];
        end
    end

    rhsm_ring #(
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (text_live),
        .wr_addr (pos_reg),
        .wr_data (in_byte),
        .rd_en   (text_live),
        .rd_addr (old_idx),
        .rd_data (old_byte)
    );

    always_comb begin
        mm_req = '0;
        case (state_reg)
            ST_PAT_POW: begin
                mm_req.start = 1'b1;
                mm_req.a     = top_reg;
                mm_req.b     = rhsm_pkg::HASH_BASE;
            end
            ST_PAT_HASH: begin
                mm_req.start = 1'b1;
                mm_req.a     = {22'd0, byte_reg};
                mm_req.b     = top_reg;
                mm_req.c     = phash_reg;
            end
            ST_FILL_HASH: begin
                mm_req.start = 1'b1;
                mm_req.a     = {22'd0, byte_reg};
                mm_req.b     = tp_reg;
                mm_req.c     = wh_reg;
            end
            ST_FILL_POW: begin
                mm_req.start = 1'b1;
                mm_req.a     = tp_reg;
                mm_req.b     = rhsm_pkg::HASH_BASE;
            end
            ST_ROLL_INV: begin
                mm_req.start = 1'b1;
                mm_req.a     = hsub;
                mm_req.b     = rhsm_pkg::HASH_BASE_INV;
            end
            ST_ROLL_ADD: begin
                mm_req.start = 1'b1;
                mm_req.a     = {22'd0, byte_reg};
                mm_req.b     = top_reg;
                mm_req.c     = wh_reg;
            end
            default: ;
        endcase
    end

    rhsm_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        rhsm_pkg::OP_PATTERN: begin
                            if (plen_reg < PLEN_MAX) begin
                                state_next = (plen_reg == '0) ? ST_PAT_HASH : ST_PAT_POW;
                            end
                        end
                        rhsm_pkg::OP_TEXT: begin
                            if (plen_reg != '0) begin
                                state_next = (fill_reg < plen_reg) ? ST_FILL_HASH
                                                                   : ST_ROLL_INV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAT_POW:   if (mm_rsp.done) state_next = ST_PAT_HASH;
            ST_PAT_HASH:  if (mm_rsp.done) state_next = ST_IDLE;
            ST_FILL_HASH: if (mm_rsp.done) state_next = ST_FILL_POW;
            ST_FILL_POW:  if (mm_rsp.done) state_next = ST_CHECK;
            ST_ROLL_INV:  if (mm_rsp.done) state_next = ST_ROLL_ADD;
            ST_ROLL_ADD:  if (mm_rsp.done) state_next = ST_CHECK;
            ST_CHECK: begin
                // Hold a match until the output register is free
                if (!match || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phash_reg <= '0;
            plen_reg  <= '0;
            top_reg   <= 30'd1;
            wh_reg    <= '0;
            tp_reg    <= 30'd1;
            count_reg <= '0;
            fill_reg  <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (in_op)
                            rhsm_pkg::OP_START: begin
                                phash_reg <= '0;
                                plen_reg  <= '0;
                                top_reg   <= 30'd1;
                                wh_reg    <= '0;
                                tp_reg    <= 30'd1;
                                count_reg <= '0;
                                fill_reg  <= '0;
                                pos_reg   <= '0;
                            end
                            rhsm_pkg::OP_PATTERN: begin
                                // Any pattern word restarts the text
                                wh_reg    <= '0;
                                tp_reg    <= 30'd1;
                                count_reg <= '0;
                                fill_reg  <= '0;
                                pos_reg   <= '0;
                            end
                            rhsm_pkg::OP_TEXT: begin
                                if (count_reg != 32'hFFFF_FFFF) begin
                                    count_reg <= count_reg + 32'd1;
                                end
                                if (plen_reg != '0) begin
                                    if (fill_reg < plen_reg) begin
                                        fill_reg <= fill_reg + PLW'(1);
                                    end
                                    pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + AW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PAT_POW:   if (mm_rsp.done) top_reg <= mm_rsp.value;
                ST_PAT_HASH: begin
                    if (mm_rsp.done) begin
                        phash_reg <= mm_rsp.value;
                        plen_reg  <= plen_reg + PLW'(1);
                    end
                end
                ST_FILL_HASH: if (mm_rsp.done) wh_reg <= mm_rsp.value;
                ST_FILL_POW:  if (mm_rsp.done) tp_reg <= mm_rsp.value;
                ST_ROLL_INV:  if (mm_rsp.done) wh_reg <= mm_rsp.value;
                ST_ROLL_ADD:  if (mm_rsp.done) wh_reg <= mm_rsp.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_CHECK) && match && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_CHECK) && match && out_free) begin
            m_tdata_reg <= count_reg - 32'(plen_reg) + 32'd1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/rhsm_checker.sv */
// ----------------------------------------------------------------------------
// Rolling hash matcher port checker
// Watches the stream ports of the matcher and flags ordering slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic in_word;

    assign in_word = s_tvalid && s_tready;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    `ASSERT_NEXT(a_start_ready, aclk, aresetn, in_word && (s_tdata[1:0] == rhsm_pkg::OP_START), s_tready, "busy after start word")

    `ASSERT_NEXT(a_pattern_quiet, aclk, aresetn, in_word && (s_tdata[1:0] == rhsm_pkg::OP_PATTERN), !$rose(m_tvalid), "result straight after pattern word")

    `ASSERT_IMPLIES(a_result_after_busy, aclk, aresetn, $rose(m_tvalid), $past(!s_tready), "result raised while idle")

endmodule

bind rolling_hash_substring_matcher rhsm_checker u_rhsm_checker (.*);
